[hdl/etfp_pkg.sv]
// shared types, constants and saturation helpers for the escape-time fractal pixel core
// no dependencies; imported by the core
package etfp_pkg;

	localparam int FRAC_BITS = 28;
	localparam int TAG_W = 3;

	localparam logic signed [47:0] ONE_Q = 48'sd1 <<< FRAC_BITS;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_MODE     = 4'd0,
		REG_X_ORIGIN = 4'd1,
		REG_Y_ORIGIN = 4'd2,
		REG_X_STEP   = 4'd3,
		REG_Y_STEP   = 4'd4,
		REG_JULIA_RE = 4'd5,
		REG_JULIA_IM = 4'd6,
		REG_MAX_ITER = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_MANDEL  = 2'd0,
		MODE_FIXED_C = 2'd1,
		MODE_DIST    = 2'd2,
		MODE_ALT     = 2'd3
	} mode_t;

	// one pixel's orbit state as it travels around the ring
	typedef struct packed {
		logic              valid;
		logic              done;
		logic              esc;
		logic              deriv_on;
		logic [TAG_W-1:0]  tag;
		logic [15:0]       count;
		logic signed [31:0] zr;
		logic signed [31:0] zi;
		logic signed [47:0] dr;
		logic signed [47:0] di;
		logic signed [31:0] cr;
		logic signed [31:0] ci;
	} slot_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > 64'sh00007fffffffffff) return 48'sh7fffffffffff;
		if (v < -64'sh0000800000000000) return 48'sh800000000000;
		return v[47:0];
	endfunction

endpackage

[hdl/etfp_pix_in_if.sv]
// pixel coordinate input channel
// depends on nothing
interface etfp_pix_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] column;
	logic [11:0] row;
	modport source (output valid, column, row, input ready);
	modport sink (input valid, column, row, output ready);
endinterface

[hdl/etfp_pix_out_if.sv]
// pixel result output channel
// depends on nothing
interface etfp_pix_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        iteration_count;
	logic               escaped;
	logic signed [31:0] exit_z_re;
	logic signed [31:0] exit_z_im;
	logic signed [47:0] exit_deriv_re;
	logic signed [47:0] exit_deriv_im;
	modport source (output valid, iteration_count, escaped, exit_z_re, exit_z_im,
		exit_deriv_re, exit_deriv_im, input ready);
	modport sink (input valid, iteration_count, escaped, exit_z_re, exit_z_im,
		exit_deriv_re, exit_deriv_im, output ready);
endinterface

[hdl/etfp_cfg_if.sv]
// configuration write channel: register index and data
// depends on nothing
interface etfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/escape_time_fractal_pixel_core.sv]
// Escape-time fractal pixel core (Mandelbrot, Julia, Mandelbrot with distance derivative)
// Each pixel (column, row) is mapped to a Q4.28 point and iterated z = z^2 + c until
// |z|^2 reaches 4 or max_iterations updates are done. Each iteration is one pass of a
// 4-stage ring pipeline; up to 4 pixels share the ring, each holding one slot. A pixel
// goes through point mapping and ring entry, makes one ring pass per escape test and
// leaves through the output register. Results leave in input order; a finished pixel
// keeps circling in its slot until it is the oldest. Configuration must be written only
// while the core holds no pixel; the core itself does not enforce this. Depends on
// etfp_pkg and the channel interfaces.
module escape_time_fractal_pixel_core
	import etfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	etfp_cfg_if.sink        cfg,
	etfp_pix_in_if.sink     pix_in,
	etfp_pix_out_if.source  pix_out
);

	// configuration registers
	logic [1:0]         mode_q;
	logic signed [31:0] x_origin_q, y_origin_q, x_step_q, y_step_q, julia_re_q, julia_im_q;
	logic [15:0]        max_iter_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_MANDEL;
			x_origin_q <= -32'sd536870912;
			y_origin_q <= -32'sd402653184;
			x_step_q   <= 32'sd262144;
			y_step_q   <= 32'sd262144;
			julia_re_q <= '0;
			julia_im_q <= '0;
			max_iter_q <= 16'd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE:     mode_q     <= cfg.data[1:0];
				REG_X_ORIGIN: x_origin_q <= cfg.data;
				REG_Y_ORIGIN: y_origin_q <= cfg.data;
				REG_X_STEP:   x_step_q   <= cfg.data;
				REG_Y_STEP:   y_step_q   <= cfg.data;
				REG_JULIA_RE: julia_re_q <= cfg.data;
				REG_JULIA_IM: julia_im_q <= cfg.data;
				REG_MAX_ITER: max_iter_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// point mapping: product stage then saturated sum into the pending slot
	logic               map_v_q;
	logic signed [44:0] xprod_q, yprod_q;
	logic               pend_v_q;
	logic signed [31:0] px_q, py_q;
	logic               insert, pend_ready, map_adv;
	logic signed [63:0] xsum, ysum;

	assign pend_ready   = !pend_v_q || insert;
	assign map_adv      = !map_v_q || pend_ready;
	assign pix_in.ready = map_adv;
	assign xsum = 64'(x_origin_q) + 64'(xprod_q);
	assign ysum = 64'(y_origin_q) + 64'(yprod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (map_adv) map_v_q <= pix_in.valid;
			if (pend_ready) pend_v_q <= map_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (map_adv && pix_in.valid) begin
			xprod_q <= $signed({1'b0, pix_in.column}) * x_step_q;
			yprod_q <= $signed({1'b0, pix_in.row}) * y_step_q;
		end
		if (pend_ready && map_v_q) begin
			px_q <= sat32(xsum);
			py_q <= sat32(ysum);
		end
	end

	// ring stage registers
	slot_t ring_s1, ring_s2, ring_s3, ring_s4;
	logic signed [63:0] zr2_s1, zi2_s1, zrzi_s1;
	logic signed [56:0] prh1_s1, prh2_s1, prl1_s1, prl2_s1;
	logic signed [56:0] pih1_s1, pih2_s1, pil1_s1, pil2_s1;
	logic               escn_s2, escn_s3;
	logic signed [37:0] nzr_s2, nzi_s2;
	logic signed [57:0] hr_s2, lr_s2, hi_s2, li_s2;
	logic signed [31:0] nzr_s3, nzi_s3;
	logic signed [47:0] ndr_s3, ndi_s3;

	logic [TAG_W-1:0] tag_in_q, tag_out_q;
	logic             out_v_q, out_free, retire;
	slot_t            ring_in, upd;

	assign out_free = !out_v_q || pix_out.ready;
	assign retire = ring_s4.valid && ring_s4.done && (ring_s4.tag == tag_out_q) && out_free;
	assign insert = pend_v_q && (!ring_s4.valid || retire);

	// ring entry: circulate the slot or load the pending pixel
	always_comb begin
		ring_in = ring_s4;
		if (retire) ring_in.valid = 1'b0;
		if (insert) begin
			ring_in.valid    = 1'b1;
			ring_in.done     = (max_iter_q == 16'd0);
			ring_in.esc      = 1'b0;
			ring_in.deriv_on = (mode_q == MODE_DIST);
			ring_in.tag      = tag_in_q;
			ring_in.count    = '0;
			ring_in.zr       = px_q;
			ring_in.zi       = py_q;
			ring_in.dr       = ONE_Q;
			ring_in.di       = '0;
			ring_in.cr       = (mode_q == MODE_FIXED_C) ? julia_re_q : px_q;
			ring_in.ci       = (mode_q == MODE_FIXED_C) ? julia_im_q : py_q;
		end
	end

	// stage 1: squares and derivative partial products (derivative split 24/24)
	logic signed [24:0] bh_dr, bh_di, bl_dr, bl_di;
	assign bh_dr = 25'($signed(ring_in.dr[47:24]));
	assign bh_di = 25'($signed(ring_in.di[47:24]));
	assign bl_dr = $signed({1'b0, ring_in.dr[23:0]});
	assign bl_di = $signed({1'b0, ring_in.di[23:0]});

	always_ff @(posedge clk) begin
		zr2_s1  <= ring_in.zr * ring_in.zr;
		zi2_s1  <= ring_in.zi * ring_in.zi;
		zrzi_s1 <= ring_in.zr * ring_in.zi;
		prh1_s1 <= ring_in.zr * bh_dr;
		prh2_s1 <= ring_in.zi * bh_di;
		prl1_s1 <= ring_in.zr * bl_dr;
		prl2_s1 <= ring_in.zi * bl_di;
		pih1_s1 <= ring_in.zr * bh_di;
		pih2_s1 <= ring_in.zi * bh_dr;
		pil1_s1 <= ring_in.zr * bl_di;
		pil2_s1 <= ring_in.zi * bl_dr;
	end

	// stage 2: escape test, new z before saturation, derivative sums
	logic [64:0]        mag;
	logic signed [64:0] sqdiff;
	assign mag    = {1'b0, zr2_s1} + {1'b0, zi2_s1};
	assign sqdiff = 65'(zr2_s1) - 65'(zi2_s1);

	always_ff @(posedge clk) begin
		escn_s2 <= (mag[64:58] != '0);
		nzr_s2  <= 38'(sqdiff >>> FRAC_BITS) + 38'(ring_s1.cr);
		nzi_s2  <= 38'(zrzi_s1 >>> (FRAC_BITS - 1)) + 38'(ring_s1.ci);
		hr_s2   <= 58'(prh1_s1) - 58'(prh2_s1);
		lr_s2   <= 58'(prl1_s1) - 58'(prl2_s1);
		hi_s2   <= 58'(pih1_s1) + 58'(pih2_s1);
		li_s2   <= 58'(pil1_s1) + 58'(pil2_s1);
	end

	// stage 3: saturate z, finish derivative (product scaled by 2 / 2^28)
	logic signed [58:0] hsum_r, hsum_i;
	assign hsum_r = 59'(hr_s2) + 59'(lr_s2 >>> 24);
	assign hsum_i = 59'(hi_s2) + 59'(li_s2 >>> 24);

	always_ff @(posedge clk) begin
		escn_s3 <= escn_s2;
		nzr_s3  <= sat32(64'(nzr_s2));
		nzi_s3  <= sat32(64'(nzi_s2));
		ndr_s3  <= sat48(64'(hsum_r >>> (FRAC_BITS - 1 - 24)) + 64'(ONE_Q));
		ndi_s3  <= sat48(64'(hsum_i >>> (FRAC_BITS - 1 - 24)));
	end

	// stage 4: escape or update decision
	always_comb begin
		upd = ring_s3;
		if (ring_s3.valid && !ring_s3.done) begin
			if (escn_s3) begin
				upd.done = 1'b1;
				upd.esc  = 1'b1;
			end else begin
				upd.count = ring_s3.count + 16'd1;
				upd.zr    = nzr_s3;
				upd.zi    = nzi_s3;
				if (ring_s3.deriv_on) begin
					upd.dr = ndr_s3;
					upd.di = ndi_s3;
				end
				if (upd.count == max_iter_q) upd.done = 1'b1;
			end
		end
	end

	// slot state, tags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_s1   <= '0;
			ring_s2   <= '0;
			ring_s3   <= '0;
			ring_s4   <= '0;
			tag_in_q  <= '0;
			tag_out_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			ring_s1 <= ring_in;
			ring_s2 <= ring_s1;
			ring_s3 <= ring_s2;
			ring_s4 <= upd;
			if (insert) tag_in_q <= tag_in_q + 1'b1;
			if (retire) tag_out_q <= tag_out_q + 1'b1;
			if (retire) out_v_q <= 1'b1;
			else if (pix_out.ready) out_v_q <= 1'b0;
		end
	end

	logic [15:0]        cnt_q;
	logic               esc_q;
	logic signed [31:0] ezr_q, ezi_q;
	logic signed [47:0] edr_q, edi_q;

	always_ff @(posedge clk) begin
		if (retire) begin
			cnt_q <= ring_s4.count;
			esc_q <= ring_s4.esc;
			ezr_q <= ring_s4.esc ? ring_s4.zr : '0;
			ezi_q <= ring_s4.esc ? ring_s4.zi : '0;
			edr_q <= ring_s4.esc ? ring_s4.dr : ONE_Q;
			edi_q <= ring_s4.esc ? ring_s4.di : '0;
		end
	end

	assign pix_out.valid           = out_v_q;
	assign pix_out.iteration_count = cnt_q;
	assign pix_out.escaped         = esc_q;
	assign pix_out.exit_z_re       = ezr_q;
	assign pix_out.exit_z_im       = ezi_q;
	assign pix_out.exit_deriv_re   = edr_q;
	assign pix_out.exit_deriv_im   = edi_q;

`ifndef SYNTHESIS
	// a pixel that never escaped ran the full limit
	assert property (@(posedge clk) disable iff (!arst_n)
		retire && !ring_s4.esc |-> ring_s4.count == max_iter_q)
		else $error("non-escaped pixel retired before the limit");

	// an escaped pixel stopped below the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		retire && ring_s4.esc |-> ring_s4.count < max_iter_q)
		else $error("escaped pixel count at or above the limit");

	// a slot is never overwritten while its pixel is still live
	assert property (@(posedge clk) disable iff (!arst_n)
		insert |-> !ring_s4.valid || retire)
		else $error("pixel inserted over a live slot");
`endif

endmodule
